@@ hdl/rlz_pkg.sv @@
// ----------------------------------------------------------------------------
// rlz_pkg: shared types and constants of the RGB LZ image decoder
// Transaction payloads, decode phases, command codes and code-field constants.
// ----------------------------------------------------------------------------
`default_nettype none

package rlz_pkg;

    // Fixed field widths
    localparam int OC_W       = 22;   // output byte count and size limit
    localparam int REM_W      = 18;   // pending run or match bytes
    localparam int CFG_DATA_W = 22;
    localparam int CFG_IDX_W  = 1;
    localparam int WIDTH_W    = 11;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_BYTES = 1'b1;

    // Configuration reset values
    localparam logic [WIDTH_W-1:0] RST_IMAGE_WIDTH  = 11'd640;
    localparam logic [OC_W-1:0]    RST_OUTPUT_BYTES = 22'd921600;

    // Smallest image width used for row distances
    localparam logic [WIDTH_W-1:0] MIN_WIDTH = 11'd4;

    // Input commands
    localparam logic [1:0] CMD_BYTE = 2'd0;
    localparam logic [1:0] CMD_PULL = 2'd1;
    localparam logic [1:0] CMD_NEW  = 2'd2;

    // Code byte fields
    localparam logic [7:0] CODE_LIT_EXT = 8'h7F;
    localparam logic [1:0] LEN_EXT      = 2'b11;
    localparam logic [7:0] LIT_EXT_BIAS = 8'd128;
    localparam logic [7:0] MAT_EXT_BIAS = 8'd4;

    // Distance slot boundaries (first slot of each row group) and biases
    localparam logic [4:0] SLOT_ROW1 = 5'd6;
    localparam logic [4:0] SLOT_ROW2 = 5'd13;
    localparam logic [4:0] SLOT_ROW3 = 5'd20;
    localparam logic [4:0] SLOT_ROW4 = 5'd27;
    localparam logic [4:0] BIAS_ROW1 = 5'd9;
    localparam logic [4:0] BIAS_ROW2 = 5'd16;
    localparam logic [4:0] BIAS_ROW3 = 5'd23;
    localparam logic [4:0] BIAS_ROW4 = 5'd29;

    // Decode phases
    typedef enum logic [2:0] {
        PH_RAW     = 3'd0,
        PH_CODE    = 3'd1,
        PH_LEXT_LO = 3'd2,
        PH_LEXT_HI = 3'd3,
        PH_MEXT_LO = 3'd4,
        PH_MEXT_HI = 3'd5,
        PH_LITERAL = 3'd6,
        PH_MATCH   = 3'd7
    } t_phase;

    // Input transaction payload
    typedef struct packed {
        logic [1:0] command;
        logic [7:0] data_byte;
        logic       end_of_stream;
    } t_in_item;

    // Result transaction payload
    typedef struct packed {
        logic             out_valid;
        logic [7:0]       out_byte;
        logic [REM_W-1:0] copy_remaining;
        logic             image_complete;
        logic             bad_reference;
        logic             input_ignored;
    } t_out_item;

    // Decoded item handed from the parser to the emit stage
    typedef struct packed {
        logic             out_valid;
        logic             from_ring;
        logic             bad;
        logic [7:0]       lit_byte;
        logic [REM_W-1:0] copy_remaining;
        logic             image_complete;
        logic             input_ignored;
    } t_s2;

endpackage

`default_nettype wire

@@ hdl/rlz_if.sv @@
// ----------------------------------------------------------------------------
// rlz_if: valid/ready channels of the RGB LZ image decoder
// One interface for the input transactions, one for the result transactions.
// ----------------------------------------------------------------------------
`default_nettype none

interface rlz_in_if import rlz_pkg::*; ();
    logic     valid;
    logic     ready;
    t_in_item payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface rlz_out_if import rlz_pkg::*; ();
    logic      valid;
    logic      ready;
    t_out_item payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

@@ hdl/rlz_ram.sv @@
// ----------------------------------------------------------------------------
// rlz_ram: generic simple dual-port RAM
// One write port and one read port with enable; read data is registered.
// ----------------------------------------------------------------------------
`default_nettype none

module rlz_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16384
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read; hold the last data while no read is issued
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

@@ hdl/rlz_parse.sv @@
// ----------------------------------------------------------------------------
// rlz_parse: code parser and history read stage
// Holds the configuration and decode state, decodes one transaction per cycle
// while the emit stage is ready, and issues the history read for match bytes.
// ----------------------------------------------------------------------------
`default_nettype none

module rlz_parse import rlz_pkg::*; #(
    parameter int MAX_WIDTH     = 1024,
    parameter int MAX_HEIGHT    = 1024,
    parameter int HISTORY_DEPTH = 16384
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]             i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0]            i_cfg_data,
    rlz_in_if.sink                                i_in,
    input  wire logic                             i_s2_ready,
    output logic                                  o_s2_load,
    output t_s2                                   o_s2,
    output logic      [$clog2(HISTORY_DEPTH)-1:0] o_wr_addr,
    output logic                                  o_rd_en,
    output logic      [$clog2(HISTORY_DEPTH)-1:0] o_rd_addr
);

    localparam int PTR_W    = $clog2(HISTORY_DEPTH);
    localparam int WCAP     = (MAX_WIDTH < 2047) ? MAX_WIDTH : 2047;
    localparam int DIST_W   = $clog2(12 * WCAP + 7);
    localparam int SUM_W    = ((DIST_W > PTR_W) ? DIST_W : PTR_W) + 2;
    localparam longint CAP  = longint'(MAX_WIDTH) * longint'(MAX_HEIGHT) * 3;
    localparam logic [OC_W-1:0] LIM_CAP =
        (CAP >= (longint'(1) << OC_W)) ? {OC_W{1'b1}} : OC_W'(CAP);

    // Configuration registers
    logic [WIDTH_W-1:0] r_width;
    logic [OC_W-1:0]    r_obytes;

    // Decode state
    t_phase             r_phase,   n_phase;
    logic [1:0]         r_raw_cnt, n_raw_cnt;
    logic [7:0]         r_ext_lo,  n_ext_lo;
    logic [REM_W-1:0]   r_rem,     n_rem;
    logic [DIST_W-1:0]  r_dist,    n_dist;
    logic [OC_W-1:0]    r_oc,      n_oc;
    logic               r_ended,   n_ended;
    logic [PTR_W-1:0]   r_wptr,    n_wptr;

    logic               accept;
    logic [7:0]         b;
    logic [WIDTH_W-1:0] eff_w;
    logic [OC_W-1:0]    limit;
    logic [OC_W-1:0]    room;
    logic [DIST_W-1:0]  w_d;
    logic [DIST_W-1:0]  p_pix;
    logic [DIST_W-1:0]  slot_dist;
    logic [4:0]         slot;
    logic [PTR_W-1:0]   wptr_inc;
    logic [SUM_W-1:0]   rd_diff;
    logic               copy_pending;
    logic               fin_now;
    logic               fin_next;
    logic               start;
    t_phase             run_phase;
    logic [REM_W-1:0]   run_len;
    logic [REM_W-1:0]   run_clip;

    function automatic logic is_finished(input logic [OC_W-1:0] oc,
                                         input logic [OC_W-1:0] lim,
                                         input t_phase ph,
                                         input logic [REM_W-1:0] rem,
                                         input logic ended);
        return (oc >= lim) || (ended && !(ph == PH_MATCH && rem != '0));
    endfunction

    // Byte count of a run of pixels
    function automatic logic [REM_W-1:0] pix_bytes(input logic [16:0] pix);
        return REM_W'(pix) + {pix, 1'b0};
    endfunction

    assign accept    = i_in.valid && i_s2_ready;
    assign i_in.ready = i_s2_ready;
    assign o_s2_load = accept;
    assign b         = i_in.payload.data_byte;

    // Clamp width and size limit
    always_comb begin
        if (r_width < MIN_WIDTH) begin
            eff_w = MIN_WIDTH;
        end else if (r_width > WIDTH_W'(WCAP)) begin
            eff_w = WIDTH_W'(WCAP);
        end else begin
            eff_w = r_width;
        end
        limit = (r_obytes > LIM_CAP) ? LIM_CAP : r_obytes;
    end

    assign room = limit - r_oc;

    // Match distance in bytes from the slot field of the code byte
    assign slot = b[6:2];
    assign w_d  = DIST_W'(eff_w);

    always_comb begin
        if (slot < SLOT_ROW1) begin
            p_pix = DIST_W'(slot) + DIST_W'(1);
        end else if (slot < SLOT_ROW2) begin
            p_pix = w_d + DIST_W'(slot) - DIST_W'(BIAS_ROW1);
        end else if (slot < SLOT_ROW3) begin
            p_pix = (w_d << 1) + DIST_W'(slot) - DIST_W'(BIAS_ROW2);
        end else if (slot < SLOT_ROW4) begin
            p_pix = w_d + (w_d << 1) + DIST_W'(slot) - DIST_W'(BIAS_ROW3);
        end else begin
            p_pix = (w_d << 2) + DIST_W'(slot) - DIST_W'(BIAS_ROW4);
        end
    end

    assign slot_dist = p_pix + (p_pix << 1);

    // Ring pointers: next write slot and match read slot
    assign wptr_inc = (r_wptr == PTR_W'(HISTORY_DEPTH - 1)) ? '0 : r_wptr + PTR_W'(1);

    always_comb begin
        rd_diff = SUM_W'(r_wptr) - SUM_W'(r_dist);
        if (rd_diff[SUM_W-1]) begin
            rd_diff = rd_diff + SUM_W'(HISTORY_DEPTH);
        end
    end

    assign o_rd_addr    = rd_diff[PTR_W-1:0];
    assign o_wr_addr    = r_wptr;
    assign copy_pending = (r_phase == PH_MATCH) && (r_rem != '0);
    assign fin_now      = is_finished(r_oc, limit, r_phase, r_rem, r_ended);

    // Next decode state and decoded item
    always_comb begin
        n_phase   = r_phase;
        n_raw_cnt = r_raw_cnt;
        n_ext_lo  = r_ext_lo;
        n_rem     = r_rem;
        n_dist    = r_dist;
        n_oc      = r_oc;
        n_ended   = r_ended;
        n_wptr    = r_wptr;
        o_rd_en   = 1'b0;
        o_s2      = '0;
        start     = 1'b0;
        run_phase = PH_CODE;
        run_len   = '0;
        run_clip  = '0;

        if (accept) begin
            unique case (i_in.payload.command)
                CMD_NEW: begin
                    n_phase   = PH_RAW;
                    n_raw_cnt = '0;
                    n_ext_lo  = '0;
                    n_rem     = '0;
                    n_dist    = '0;
                    n_oc      = '0;
                    n_ended   = 1'b0;
                    n_wptr    = '0;
                end
                CMD_PULL: begin
                    if (!fin_now && copy_pending) begin
                        o_rd_en          = 1'b1;
                        o_s2.out_valid   = 1'b1;
                        o_s2.from_ring   = 1'b1;
                        o_s2.bad         = !((OC_W'(r_dist) <= r_oc) &&
                                             (32'(r_dist) <= 32'(HISTORY_DEPTH)));
                        n_oc             = r_oc + OC_W'(1);
                        n_wptr           = wptr_inc;
                        n_rem            = r_rem - REM_W'(1);
                        if (r_rem == REM_W'(1)) begin
                            n_phase = PH_CODE;
                        end
                    end
                end
                CMD_BYTE: begin
                    if (fin_now || copy_pending) begin
                        o_s2.input_ignored = 1'b1;
                    end else begin
                        unique case (r_phase)
                            PH_RAW: begin
                                o_s2.out_valid = 1'b1;
                                o_s2.lit_byte  = b;
                                n_oc           = r_oc + OC_W'(1);
                                n_wptr         = wptr_inc;
                                if (r_raw_cnt == 2'd2) begin
                                    n_raw_cnt = '0;
                                    n_phase   = PH_CODE;
                                end else begin
                                    n_raw_cnt = r_raw_cnt + 2'd1;
                                end
                            end
                            PH_CODE: begin
                                if (b == CODE_LIT_EXT) begin
                                    n_phase = PH_LEXT_LO;
                                end else if (b < CODE_LIT_EXT) begin
                                    start     = 1'b1;
                                    run_phase = PH_LITERAL;
                                    run_len   = pix_bytes(17'(b) + 17'd1);
                                end else begin
                                    n_dist = slot_dist;
                                    if (b[1:0] == LEN_EXT) begin
                                        n_phase = PH_MEXT_LO;
                                    end else begin
                                        start     = 1'b1;
                                        run_phase = PH_MATCH;
                                        run_len   = pix_bytes(17'(b[1:0]) + 17'd1);
                                    end
                                end
                            end
                            PH_LEXT_LO: begin
                                n_ext_lo = b;
                                n_phase  = PH_LEXT_HI;
                            end
                            PH_MEXT_LO: begin
                                n_ext_lo = b;
                                n_phase  = PH_MEXT_HI;
                            end
                            PH_LEXT_HI: begin
                                start     = 1'b1;
                                run_phase = PH_LITERAL;
                                run_len   = pix_bytes(17'({b, r_ext_lo}) + 17'(LIT_EXT_BIAS));
                            end
                            PH_MEXT_HI: begin
                                start     = 1'b1;
                                run_phase = PH_MATCH;
                                run_len   = pix_bytes(17'({b, r_ext_lo}) + 17'(MAT_EXT_BIAS));
                            end
                            PH_LITERAL, PH_MATCH: begin
                                o_s2.out_valid = 1'b1;
                                o_s2.lit_byte  = b;
                                n_oc           = r_oc + OC_W'(1);
                                n_wptr         = wptr_inc;
                                n_rem          = r_rem - REM_W'(1);
                                if (r_rem == REM_W'(1)) begin
                                    n_phase = PH_CODE;
                                end
                            end
                            default: ;
                        endcase

                        // Clip a new run at the remaining image size
                        if (start) begin
                            run_clip = (OC_W'(run_len) > room) ? REM_W'(room) : run_len;
                            n_rem    = run_clip;
                            n_phase  = (run_clip != '0) ? run_phase : PH_CODE;
                        end

                        // Close the stream; only a pending match survives
                        if (i_in.payload.end_of_stream) begin
                            n_ended = 1'b1;
                            if (n_phase != PH_MATCH) begin
                                n_rem = '0;
                            end
                        end
                    end
                end
                default: ;
            endcase
        end

        fin_next            = is_finished(n_oc, limit, n_phase, n_rem, n_ended);
        o_s2.image_complete = fin_next;
        o_s2.copy_remaining = fin_next ? '0 : n_rem;
    end

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= RST_IMAGE_WIDTH;
            r_obytes <= RST_OUTPUT_BYTES;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_IMAGE_WIDTH:  r_width  <= i_cfg_data[WIDTH_W-1:0];
                CFG_OUTPUT_BYTES: r_obytes <= i_cfg_data[OC_W-1:0];
            endcase
        end
    end

    // Decode state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_RAW;
            r_raw_cnt <= '0;
            r_ext_lo  <= '0;
            r_rem     <= '0;
            r_dist    <= '0;
            r_oc      <= '0;
            r_ended   <= 1'b0;
            r_wptr    <= '0;
        end else begin
            r_phase   <= n_phase;
            r_raw_cnt <= n_raw_cnt;
            r_ext_lo  <= n_ext_lo;
            r_rem     <= n_rem;
            r_dist    <= n_dist;
            r_oc      <= n_oc;
            r_ended   <= n_ended;
            r_wptr    <= n_wptr;
        end
    end

endmodule

`default_nettype wire

@@ hdl/rlz_emit.sv @@
// ----------------------------------------------------------------------------
// rlz_emit: history write-back and result register
// Merges the history read data into the decoded item, writes every output
// byte back to the ring and holds results for the output channel.
// ----------------------------------------------------------------------------
`default_nettype none

module rlz_emit import rlz_pkg::*; #(
    parameter int HISTORY_DEPTH = 16384
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_load,
    input  wire t_s2                              i_s2,
    input  wire logic [$clog2(HISTORY_DEPTH)-1:0] i_wr_addr,
    input  wire logic [7:0]                       i_rd_data,
    output logic                                  o_s2_ready,
    output logic                                  o_ring_we,
    output logic      [$clog2(HISTORY_DEPTH)-1:0] o_ring_wr_addr,
    output logic      [7:0]                       o_ring_wr_data,
    rlz_out_if.source                             o_out
);

    localparam int PTR_W = $clog2(HISTORY_DEPTH);

    logic             r_s2_v;
    t_s2              r_s2;
    logic [PTR_W-1:0] r_wr_addr;
    logic             r_out_v;
    t_out_item        r_out;
    logic             s2_adv;
    logic [7:0]       byte_sel;
    t_out_item        res;

    assign s2_adv     = !r_out_v || o_out.ready;
    assign o_s2_ready = !r_s2_v || s2_adv;

    // Pick the result byte: literal, history, or zero for a bad reference
    always_comb begin
        if (!r_s2.out_valid) begin
            byte_sel = '0;
        end else if (r_s2.from_ring) begin
            byte_sel = r_s2.bad ? 8'h00 : i_rd_data;
        end else begin
            byte_sel = r_s2.lit_byte;
        end
        res.out_valid      = r_s2.out_valid;
        res.out_byte       = byte_sel;
        res.copy_remaining = r_s2.copy_remaining;
        res.image_complete = r_s2.image_complete;
        res.bad_reference  = r_s2.bad;
        res.input_ignored  = r_s2.input_ignored;
    end

    // Write every emitted byte back to the ring as it leaves this stage
    assign o_ring_we      = s2_adv && r_s2_v && r_s2.out_valid;
    assign o_ring_wr_addr = r_wr_addr;
    assign o_ring_wr_data = byte_sel;

    // Stage valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_v  <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            if (o_s2_ready) begin
                r_s2_v <= i_load;
            end
            if (s2_adv) begin
                r_out_v <= r_s2_v;
            end
        end
    end

    // Stage payloads
    always_ff @(posedge i_clk) begin
        if (o_s2_ready && i_load) begin
            r_s2      <= i_s2;
            r_wr_addr <= i_wr_addr;
        end
        if (s2_adv && r_s2_v) begin
            r_out <= res;
        end
    end

    assign o_out.valid   = r_out_v;
    assign o_out.payload = r_out;

endmodule

`default_nettype wire

@@ hdl/rgb_lz_image_decoder.sv @@
// ----------------------------------------------------------------------------
// rgb_lz_image_decoder: byte-serial LZ decoder for 24-bit RGB images
// Decodes raw, literal-run and 2D back-reference codes; match bytes are
// pulled one per transaction from a ring of recent output bytes.
// ----------------------------------------------------------------------------
//  Channel  Dir  Contents                                        Transfer
//  i_in     in   command, data_byte, end_of_stream               valid & ready
//  o_out    out  out_valid, out_byte, copy_remaining, status     valid & ready
//  cfg      in   i_cfg_we, i_cfg_index, i_cfg_data               i_cfg_we
//
//  One input transaction per cycle while o_out takes results; each result is
//  held in the emit stage register and then in the result register.
//  The rate is set by the history ring: one read port for match bytes and
//  one write port for every emitted byte, each used once per transaction.
//  Synchronous active-low reset clears control state; the ring is not cleared.
//  Once o_out stalls, the two result slots take at most one more input
//  transaction; then the input waits until o_out moves.
// ----------------------------------------------------------------------------
`default_nettype none

module rgb_lz_image_decoder import rlz_pkg::*; #(
    parameter int MAX_WIDTH     = 1024,
    parameter int MAX_HEIGHT    = 1024,
    parameter int HISTORY_DEPTH = 16384
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    rlz_in_if.sink                     i_in,
    rlz_out_if.source                  o_out
);

    localparam int PTR_W = $clog2(HISTORY_DEPTH);

    logic             s2_ready;
    logic             s2_load;
    t_s2              s2;
    logic [PTR_W-1:0] s2_wr_addr;
    logic             rd_en;
    logic [PTR_W-1:0] rd_addr;
    logic [7:0]       rd_data;
    logic             ring_we;
    logic [PTR_W-1:0] ring_wr_addr;
    logic [7:0]       ring_wr_data;

    // Parse codes and issue history reads
    rlz_parse #(
        .MAX_WIDTH     (MAX_WIDTH),
        .MAX_HEIGHT    (MAX_HEIGHT),
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_parse (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in        (i_in),
        .i_s2_ready  (s2_ready),
        .o_s2_load   (s2_load),
        .o_s2        (s2),
        .o_wr_addr   (s2_wr_addr),
        .o_rd_en     (rd_en),
        .o_rd_addr   (rd_addr)
    );

    // History ring
    rlz_ram #(
        .WIDTH (8),
        .DEPTH (HISTORY_DEPTH)
    ) u_ring (
        .i_clk     (i_clk),
        .i_we      (ring_we),
        .i_wr_addr (ring_wr_addr),
        .i_wr_data (ring_wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // Write back and hold results
    rlz_emit #(
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_emit (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_load         (s2_load),
        .i_s2           (s2),
        .i_wr_addr      (s2_wr_addr),
        .i_rd_data      (rd_data),
        .o_s2_ready     (s2_ready),
        .o_ring_we      (ring_we),
        .o_ring_wr_addr (ring_wr_addr),
        .o_ring_wr_data (ring_wr_data),
        .o_out          (o_out)
    );

endmodule

`default_nettype wire
